// ----- hw/rtl/gpmm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpmm_pkg
// Shared types and constants of the greedy parallel machine makespan block.
// ----------------------------------------------------------------------------
package gpmm_pkg;

	localparam int TIME_W           = 12;
	localparam int JOBS_W           = 32;
	localparam int WORD_W           = 64;
	localparam int TOTAL_W          = 63;
	localparam int DEF_MAX_MACHINES = 16;

	localparam logic [WORD_W-1:0] MAX63      = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [WORD_W-1:0] PERIOD_CAP = 64'h0000_0002_0000_0000;

	typedef struct packed {
		logic [TIME_W-1:0] machine_time;
		logic              last_machine;
	} in_item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_time;
		logic               overflow;
	} out_item_t;

	// Request and response of the serial divider.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quotient;
		logic [WORD_W-1:0] remainder;
	} div_rsp_t;

	// Request and response of the serial multiplier.
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] product;
		logic              ovf;
	} mul_rsp_t;

endpackage : gpmm_pkg
`default_nettype wire

// ----- hw/rtl/gpmm_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpmm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gpmm_div (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gpmm_pkg::div_req_t  req,
	output gpmm_pkg::div_rsp_t  rsp
);
	import gpmm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;

	logic [WORD_W:0] shifted;
	logic [WORD_W:0] trial;
	logic            ge;

	assign shifted = {rem_q, quo_q[WORD_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign ge      = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? trial[WORD_W-1:0] : shifted[WORD_W-1:0];
			quo_q <= {quo_q[WORD_W-2:0], ge};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule : gpmm_div
`default_nettype wire

// ----- hw/rtl/gpmm_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpmm_mul
// Shift and add multiplier, most significant bit first, with a sticky flag
// that is set once the product passes 63 bits.
// ----------------------------------------------------------------------------
module gpmm_mul (
	input  wire                 clk,
	input  wire                 arst_n,
	input  gpmm_pkg::mul_req_t  req,
	output gpmm_pkg::mul_rsp_t  rsp
);
	import gpmm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] acc_q;
	logic              ovf_q;

	logic [WORD_W:0] sum;

	assign sum = {acc_q, 1'b0} + (b_q[WORD_W-1] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			acc_q <= sum[WORD_W-1:0];
			ovf_q <= ovf_q | sum[WORD_W] | sum[WORD_W-1];
			b_q   <= {b_q[WORD_W-2:0], 1'b0};
		end
	end

	assign rsp.done    = done_q;
	assign rsp.product = acc_q;
	assign rsp.ovf     = ovf_q;

endmodule : gpmm_mul
`default_nettype wire

// ----- hw/rtl/greedy_parallel_machine_makespan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_parallel_machine_makespan
// Finish time of job_count equal jobs placed greedily on parallel machines.
// ----------------------------------------------------------------------------
// Usage: machine job times arrive on the input channel (in_valid, in_stall,
// in_item), one transaction per machine and one per cycle while the block is
// idle. The transaction whose last_machine bit is set closes the set and
// starts the computation; times beyond MAX_MACHINES are dropped. A time of
// zero counts as one. The job count is written through cfg_we and cfg_wdata
// by the user, who must do so only while the block is idle; the block itself
// does not enforce this. After the closing transaction in_stall stays high
// while a sequencer drives one serial divider and one serial multiplier: the
// period lcm needs a few divisions plus one product per machine, every step
// of the binary search for the last finish time (at most about 46 steps)
// needs one division per machine, and placing the remainder needs three
// operations per machine.
// One result transaction appears on out_valid/out_item per closing input.
// It sits in an output register; a stalled receiver holds it there while new
// times are loaded, and only the next result waits for it to be taken.
// Reset clears the job count, the machine count and the output valid flag.
// ----------------------------------------------------------------------------
module greedy_parallel_machine_makespan #(
	parameter int MAX_MACHINES = gpmm_pkg::DEF_MAX_MACHINES
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  gpmm_pkg::in_item_t            in_item,
	output logic                          out_valid,
	input  wire                           out_stall,
	output gpmm_pkg::out_item_t           out_item,
	input  wire                           cfg_we,
	input  wire [gpmm_pkg::JOBS_W-1:0]    cfg_wdata
);
	import gpmm_pkg::*;

	localparam int CNT_W = $clog2(MAX_MACHINES + 1);
	localparam int IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MACHINES);

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_LCM_NEXT, S_GCD_W, S_PART_W, S_LCM_MUL_W,
		S_JPP_NEXT, S_JPP_W, S_QR_W, S_SKIP_W, S_HI_W, S_BS_CHECK,
		S_BS_NEXT, S_BS_W, S_LA_NEXT, S_LA_W, S_LB_NEXT, S_LB_W,
		S_LB_MUL_W, S_FINAL, S_OUT
	} state_t;

	state_t            state_q;
	logic [JOBS_W-1:0] job_count_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic [TIME_W-1:0] times_q [MAX_MACHINES];

	logic [WORD_W-1:0] lcm_q;
	logic [TIME_W-1:0] mint_q;
	logic [TIME_W-1:0] gb_q;
	logic [WORD_W-1:0] jpp_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] skipped_q;
	logic [WORD_W-1:0] lo_q;
	logic [WORD_W-1:0] hi_q;
	logic [WORD_W-1:0] mid_q;
	logic [WORD_W-1:0] sum_q;
	logic [WORD_W-1:0] need_q;
	logic [WORD_W-1:0] best_q;
	out_item_t         res_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              div_start_q;
	logic [WORD_W-1:0] div_a_q;
	logic [WORD_W-1:0] div_b_q;
	logic              mul_start_q;
	logic [WORD_W-1:0] mul_a_q;
	logic [WORD_W-1:0] mul_b_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	assign div_req = '{start: div_start_q, dividend: div_a_q, divisor: div_b_q};
	assign mul_req = '{start: mul_start_q, a: mul_a_q, b: mul_b_q};

	gpmm_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));
	gpmm_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));

	// Time of the machine under the index counter, widened to a full word.
	logic [TIME_W-1:0] t_sel;
	logic [WORD_W-1:0] t_word;
	logic [TIME_W-1:0] t_in;
	logic              in_acc;
	logic              out_free;
	logic [WORD_W-1:0] jpp_sum;
	logic [WORD_W-1:0] q_minus;
	logic              bump;
	logic [WORD_W-1:0] final_sum;

	assign t_sel     = times_q[idx_q[IDX_W-1:0]];
	assign t_word    = {{(WORD_W-TIME_W){1'b0}}, t_sel};
	assign t_in      = (in_item.machine_time == '0) ? TIME_W'(1) : in_item.machine_time;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign jpp_sum   = jpp_q + div_rsp.quotient;
	// Jobs that finish strictly before the probe time: floor((lo - 1) / t).
	assign q_minus   = (div_rsp.remainder == '0) ? div_rsp.quotient - 64'd1
	                                             : div_rsp.quotient;
	assign bump      = (div_rsp.remainder == '0) && (need_q != '0);
	assign final_sum = skipped_q + best_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_count_q <= '0;
		end else if (cfg_we) begin
			job_count_q <= cfg_wdata;
		end
	end

	// Job time store, written while loading.
	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CNT_MAX)) begin
			times_q[cnt_q[IDX_W-1:0]] <= t_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			mul_start_q <= 1'b0;
			if (out_valid_q && !out_stall && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_item.last_machine) begin
							n_q     <= (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
							cnt_q   <= '0;
							idx_q   <= '0;
							state_q <= S_START;
						end else if (cnt_q < CNT_MAX) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_START: begin
					lcm_q   <= t_word;
					mint_q  <= t_sel;
					idx_q   <= CNT_W'(1);
					state_q <= S_LCM_NEXT;
				end
				S_LCM_NEXT: begin
					if (idx_q == n_q) begin
						jpp_q   <= '0;
						idx_q   <= '0;
						state_q <= S_JPP_NEXT;
					end else begin
						gb_q        <= t_sel;
						div_start_q <= 1'b1;
						div_a_q     <= lcm_q;
						div_b_q     <= t_word;
						state_q     <= S_GCD_W;
					end
				end
				S_GCD_W: begin
					if (div_rsp.done) begin
						div_start_q <= 1'b1;
						if (div_rsp.remainder == '0) begin
							// gcd found: divide the lcm by it.
							div_a_q <= lcm_q;
							div_b_q <= {{(WORD_W-TIME_W){1'b0}}, gb_q};
							state_q <= S_PART_W;
						end else begin
							gb_q    <= div_rsp.remainder[TIME_W-1:0];
							div_a_q <= {{(WORD_W-TIME_W){1'b0}}, gb_q};
							div_b_q <= div_rsp.remainder;
						end
					end
				end
				S_PART_W: begin
					if (div_rsp.done) begin
						mul_start_q <= 1'b1;
						mul_a_q     <= div_rsp.quotient;
						mul_b_q     <= t_word;
						state_q     <= S_LCM_MUL_W;
					end
				end
				S_LCM_MUL_W: begin
					if (mul_rsp.done) begin
						if (mul_rsp.ovf) begin
							res_q   <= '{total_time: MAX63[TOTAL_W-1:0], overflow: 1'b1};
							state_q <= S_OUT;
						end else begin
							lcm_q   <= mul_rsp.product;
							if (t_sel < mint_q) begin
								mint_q <= t_sel;
							end
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_LCM_NEXT;
						end
					end
				end
				S_JPP_NEXT: begin
					div_start_q <= 1'b1;
					if (idx_q == n_q) begin
						div_a_q <= {{(WORD_W-JOBS_W){1'b0}}, job_count_q};
						div_b_q <= jpp_q;
						state_q <= S_QR_W;
					end else begin
						div_a_q <= lcm_q;
						div_b_q <= t_word;
						state_q <= S_JPP_W;
					end
				end
				S_JPP_W: begin
					if (div_rsp.done) begin
						jpp_q   <= (jpp_sum > PERIOD_CAP) ? PERIOD_CAP : jpp_sum;
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_JPP_NEXT;
					end
				end
				S_QR_W: begin
					if (div_rsp.done) begin
						rem_q       <= div_rsp.remainder;
						mul_start_q <= 1'b1;
						mul_a_q     <= lcm_q;
						mul_b_q     <= div_rsp.quotient;
						state_q     <= S_SKIP_W;
					end
				end
				S_SKIP_W: begin
					if (mul_rsp.done) begin
						skipped_q <= mul_rsp.product;
						best_q    <= '0;
						lo_q      <= 64'd1;
						if (mul_rsp.ovf) begin
							res_q   <= '{total_time: MAX63[TOTAL_W-1:0], overflow: 1'b1};
							state_q <= S_OUT;
						end else if (rem_q == '0) begin
							state_q <= S_FINAL;
						end else begin
							mul_start_q <= 1'b1;
							mul_a_q     <= rem_q;
							mul_b_q     <= {{(WORD_W-TIME_W){1'b0}}, mint_q};
							state_q     <= S_HI_W;
						end
					end
				end
				S_HI_W: begin
					if (mul_rsp.done) begin
						hi_q    <= mul_rsp.product;
						state_q <= S_BS_CHECK;
					end
				end
				S_BS_CHECK: begin
					sum_q <= '0;
					idx_q <= '0;
					if (lo_q < hi_q) begin
						mid_q   <= lo_q + ((hi_q - lo_q) >> 1);
						state_q <= S_BS_NEXT;
					end else begin
						state_q <= S_LA_NEXT;
					end
				end
				S_BS_NEXT: begin
					if (idx_q == n_q) begin
						if (sum_q >= rem_q) begin
							hi_q <= mid_q;
						end else begin
							lo_q <= mid_q + 64'd1;
						end
						state_q <= S_BS_CHECK;
					end else begin
						div_start_q <= 1'b1;
						div_a_q     <= mid_q;
						div_b_q     <= t_word;
						state_q     <= S_BS_W;
					end
				end
				S_BS_W: begin
					if (div_rsp.done) begin
						sum_q   <= sum_q + div_rsp.quotient;
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_BS_NEXT;
					end
				end
				S_LA_NEXT: begin
					if (idx_q == n_q) begin
						need_q  <= rem_q - sum_q;
						idx_q   <= '0;
						state_q <= S_LB_NEXT;
					end else begin
						div_start_q <= 1'b1;
						div_a_q     <= lo_q;
						div_b_q     <= t_word;
						state_q     <= S_LA_W;
					end
				end
				S_LA_W: begin
					if (div_rsp.done) begin
						sum_q   <= sum_q + q_minus;
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_LA_NEXT;
					end
				end
				S_LB_NEXT: begin
					if (idx_q == n_q) begin
						state_q <= S_FINAL;
					end else begin
						div_start_q <= 1'b1;
						div_a_q     <= lo_q;
						div_b_q     <= t_word;
						state_q     <= S_LB_W;
					end
				end
				S_LB_W: begin
					if (div_rsp.done) begin
						// Ties at the probe time go to the lowest indexes first.
						if (bump) begin
							need_q <= need_q - 64'd1;
						end
						mul_start_q <= 1'b1;
						mul_a_q     <= q_minus + {63'd0, bump};
						mul_b_q     <= t_word;
						state_q     <= S_LB_MUL_W;
					end
				end
				S_LB_MUL_W: begin
					if (mul_rsp.done) begin
						if (mul_rsp.product > best_q) begin
							best_q <= mul_rsp.product;
						end
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= S_LB_NEXT;
					end
				end
				S_FINAL: begin
					if (final_sum > MAX63) begin
						res_q <= '{total_time: MAX63[TOTAL_W-1:0], overflow: 1'b1};
					end else begin
						res_q <= '{total_time: final_sum[TOTAL_W-1:0], overflow: 1'b0};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && out_free) begin
			out_q <= res_q;
		end
	end

`ifndef SYNTHESIS
	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.overflow |-> (out_q.total_time == MAX63[TOTAL_W-1:0]))
		else $error("overflow result is not saturated");

	a_one_unit_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_start_q && mul_start_q))
		else $error("divider and multiplier started together");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_MAX) && (n_q <= CNT_MAX))
		else $error("machine count beyond capacity");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BS_CHECK) |-> (lo_q <= hi_q))
		else $error("binary search bounds crossed");
`endif

endmodule : greedy_parallel_machine_makespan
`default_nettype wire
